// File: design/word_substring_matcher_assert.svh
`ifndef WORD_SUBSTRING_MATCHER_ASSERT_SVH
`define WORD_SUBSTRING_MATCHER_ASSERT_SVH

// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef NO_ASSERTIONS
`define WSM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WSM_ASSERT(lbl, prop, msg) \
  `WSM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define WSM_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define WSM_ASSERT(lbl, prop, msg)
`endif

`endif

// File: design/wsm_pkg.sv
package wsm_pkg;

  localparam int unsigned MaxPatternDefault = 25;
  localparam int unsigned PatBytes          = 25;
  localparam int unsigned CfgIdxW           = 3;
  localparam int unsigned CfgDataW          = 64;
  localparam int unsigned OutDepth          = 4;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatLen  = 3'd0,
    RegChars0  = 3'd1,
    RegChars1  = 3'd2,
    RegChars2  = 3'd3,
    RegChars3  = 3'd4
  } wsm_reg_e;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } wsm_in_t;

  typedef struct packed {
    logic        report_kind;
    logic [31:0] word_number;
    logic [31:0] matches_total;
    logic        final_flag;
  } wsm_out_t;

  typedef struct packed {
    logic [1:0] num;
    wsm_out_t   first;
    wsm_out_t   second;
  } wsm_push_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5a)) ||
           ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= 8'h41) && (c <= 8'h5a)) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

endpackage

// File: design/wsm_cfg.sv
module wsm_cfg #(
  parameter int unsigned MaxPattern = wsm_pkg::MaxPatternDefault,
  parameter int unsigned CntW       = $clog2(MaxPattern + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wsm_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [CntW-1:0]              pat_len_o,
  output logic [MaxPattern-1:0][7:0]   pat_win_o
);

  logic [4:0]  len_raw_q;
  logic [63:0] chars0_q, chars1_q, chars2_q;
  logic [7:0]  chars3_q;

  logic [wsm_pkg::PatBytes-1:0][7:0] bytes;
  logic [6:0]                        len_ext;
  logic [CntW-1:0]                   len_d, len_q;
  logic [MaxPattern-1:0][7:0]        win_d, win_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_raw_q <= '0;
      chars0_q  <= '0;
      chars1_q  <= '0;
      chars2_q  <= '0;
      chars3_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wsm_pkg::RegPatLen: len_raw_q <= cfg_data_i[4:0];
        wsm_pkg::RegChars0: chars0_q  <= cfg_data_i;
        wsm_pkg::RegChars1: chars1_q  <= cfg_data_i;
        wsm_pkg::RegChars2: chars2_q  <= cfg_data_i;
        wsm_pkg::RegChars3: chars3_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign bytes = {chars3_q, chars2_q, chars1_q, chars0_q};

  // clip length, then lay the pattern out backwards so entry j lines up with window entry j
  always_comb begin
    logic [6:0] idx;
    len_ext = {2'b00, len_raw_q};
    if (len_ext > 7'(MaxPattern)) begin
      len_d = CntW'(MaxPattern);
    end else begin
      len_d = CntW'(len_ext);
    end
    for (int j = 0; j < MaxPattern; j++) begin
      idx      = 7'({{(7-CntW){1'b0}}, len_d} - 7'd1 - 7'(j));
      win_d[j] = 8'h00;
      if ((CntW'(j) < len_d) && (idx < 7'(wsm_pkg::PatBytes))) begin
        win_d[j] = wsm_pkg::to_lower(bytes[idx[4:0]]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      win_q <= '0;
    end else begin
      len_q <= len_d;
      win_q <= win_d;
    end
  end

  assign pat_len_o = len_q;
  assign pat_win_o = win_q;

endmodule

// File: design/wsm_scan.sv
`include "word_substring_matcher_assert.svh"

module wsm_scan #(
  parameter int unsigned MaxPattern = wsm_pkg::MaxPatternDefault,
  parameter int unsigned CntW       = $clog2(MaxPattern + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  wsm_pkg::wsm_in_t           in_item_i,
  output logic                       in_stall_o,
  input  logic [CntW-1:0]            pat_len_i,
  input  logic [MaxPattern-1:0][7:0] pat_win_i,
  input  logic                       room2_i,
  output wsm_pkg::wsm_push_t         push_o
);

  logic             stg_valid_d, stg_valid_q;
  wsm_pkg::wsm_in_t stg_item_q;
  logic             accept, advance;

  logic [MaxPattern-1:0][7:0] win_d, win_q, win_n;
  logic [CntW-1:0]            cnt_d, cnt_q, cnt_base, cnt_n;
  logic                       inside_d, inside_q, hit_d, hit_q, hit_n, inside_n;
  logic [31:0]                word_ctr_d, word_ctr_q, word_ctr_n;
  logic [31:0]                hit_ctr_d, hit_ctr_q, hit_ctr_n;
  logic                       alnum, start, match, ends, report, eot;

  assign in_stall_o  = stg_valid_q && !room2_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign advance     = stg_valid_q && room2_i;
  assign stg_valid_d = accept || (stg_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_item_q <= in_item_i;
    end
  end

  assign eot   = stg_item_q.end_of_text;
  assign alnum = wsm_pkg::is_alnum(stg_item_q.text_char);
  assign start = alnum && !inside_q;

  always_comb begin
    win_n[0] = alnum ? wsm_pkg::to_lower(stg_item_q.text_char) : win_q[0];
    for (int j = 1; j < MaxPattern; j++) begin
      win_n[j] = alnum ? win_q[j-1] : win_q[j];
    end
  end

  assign cnt_base = start ? '0 : cnt_q;

  always_comb begin
    cnt_n = cnt_q;
    if (alnum) begin
      cnt_n = (cnt_base == CntW'(MaxPattern)) ? cnt_base : cnt_base + CntW'(1);
    end
  end

  // tail of the window against the pattern, empty pattern always hits
  always_comb begin
    match = (cnt_n >= pat_len_i);
    for (int j = 0; j < MaxPattern; j++) begin
      if ((CntW'(j) < pat_len_i) && (win_n[j] != pat_win_i[j])) begin
        match = 1'b0;
      end
    end
  end

  assign word_ctr_n = start ? wsm_pkg::sat_inc(word_ctr_q) : word_ctr_q;
  assign hit_n      = (start ? 1'b0 : hit_q) || (alnum && match);
  assign inside_n   = inside_q || alnum;
  assign ends       = inside_n && (!alnum || eot);
  assign report     = ends && hit_n;
  assign hit_ctr_n  = report ? wsm_pkg::sat_inc(hit_ctr_q) : hit_ctr_q;

  always_comb begin
    win_d      = win_q;
    cnt_d      = cnt_q;
    inside_d   = inside_q;
    hit_d      = hit_q;
    word_ctr_d = word_ctr_q;
    hit_ctr_d  = hit_ctr_q;
    if (advance) begin
      if (eot) begin
        win_d      = '0;
        cnt_d      = '0;
        inside_d   = 1'b0;
        hit_d      = 1'b0;
        word_ctr_d = '0;
        hit_ctr_d  = '0;
      end else begin
        win_d      = win_n;
        word_ctr_d = word_ctr_n;
        hit_ctr_d  = hit_ctr_n;
        if (ends) begin
          cnt_d    = '0;
          inside_d = 1'b0;
          hit_d    = 1'b0;
        end else begin
          cnt_d    = cnt_n;
          inside_d = inside_n;
          hit_d    = hit_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      cnt_q      <= '0;
      inside_q   <= 1'b0;
      hit_q      <= 1'b0;
      word_ctr_q <= '0;
      hit_ctr_q  <= '0;
    end else begin
      win_q      <= win_d;
      cnt_q      <= cnt_d;
      inside_q   <= inside_d;
      hit_q      <= hit_d;
      word_ctr_q <= word_ctr_d;
      hit_ctr_q  <= hit_ctr_d;
    end
  end

  // word report goes first, summary after it
  always_comb begin
    wsm_pkg::wsm_out_t word_res, sum_res;
    word_res.report_kind   = 1'b0;
    word_res.word_number   = word_ctr_n;
    word_res.matches_total = hit_ctr_n;
    word_res.final_flag    = 1'b0;
    sum_res.report_kind    = 1'b1;
    sum_res.word_number    = '0;
    sum_res.matches_total  = hit_ctr_n;
    sum_res.final_flag     = 1'b1;
    push_o.num    = '0;
    push_o.first  = report ? word_res : sum_res;
    push_o.second = sum_res;
    if (advance) begin
      push_o.num = 2'({1'b0, report} + {1'b0, eot});
    end
  end

  `WSM_ASSERT(a_stage_hold, stg_valid_q && !advance |=> stg_valid_q && $stable(stg_item_q), "stalled item lost")
  `WSM_ASSERT(a_eot_clear, advance && eot |=> !inside_q && (word_ctr_q == '0) && (hit_ctr_q == '0), "text state not cleared after summary")
  `WSM_ASSERT(a_hits_le_words, hit_ctr_q <= word_ctr_q, "more matching words than words")

endmodule

// File: design/wsm_out_fifo.sv
`include "word_substring_matcher_assert.svh"

module wsm_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wsm_pkg::wsm_push_t push_i,
  output logic               room2_o,
  output logic               out_valid_o,
  output wsm_pkg::wsm_out_t  out_item_o,
  input  logic               out_stall_i
);

  localparam int unsigned PtrW = $clog2(wsm_pkg::OutDepth);
  localparam int unsigned CntW = $clog2(wsm_pkg::OutDepth + 1);

  wsm_pkg::wsm_out_t mem_q [wsm_pkg::OutDepth];
  logic [PtrW-1:0]   wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q, wr_ptr_nx;
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic              pop;
  logic              pop_only;
  logic              held;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign room2_o     = (cnt_q <= CntW'(wsm_pkg::OutDepth - 2));
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nx   = wr_ptr_q + PtrW'(1);
  assign pop_only    = pop && (push_i.num == 2'd0);
  assign held        = out_valid_o && out_stall_i;

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.num);
  assign rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
  assign cnt_d    = cnt_q + CntW'(push_i.num) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

  `WSM_ASSERT(a_fill_bound, cnt_q <= CntW'(wsm_pkg::OutDepth), "output queue overfilled")
  `WSM_ASSERT(a_pop_only, pop_only |=> cnt_q == $past(cnt_q) - CntW'(1), "count off after pop")
  `WSM_ASSERT(a_out_hold, held |=> out_valid_o && $stable(out_item_o), "stalled item changed")

endmodule

// File: design/word_substring_matcher.sv
// channel  | dir | handshake                | payload
// cfg      | in  | cfg_valid_i/cfg_ready_o  | cfg_index_i, cfg_data_i
// in       | in  | in_valid_i/in_stall_o    | in_item_i (wsm_in_t)
// out      | out | out_valid_o/out_stall_i  | out_item_o (wsm_out_t)
//
// one item per cycle unless stalled, compared combinationally after the input register
// results pass the input register and output queue; a summary queues behind a word report
// four-entry output queue soaks up stalls; staged item and under two free raise in_stall_o
// asynchronous active-low reset clears control registers, counters and the text window
// a register write reaches the compare through the config and pattern registers
module word_substring_matcher #(
  parameter int unsigned MaxPattern = wsm_pkg::MaxPatternDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wsm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  wsm_pkg::wsm_in_t             in_item_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  output wsm_pkg::wsm_out_t            out_item_o,
  input  logic                         out_stall_i
);

  localparam int unsigned CntW = $clog2(MaxPattern + 1);

  logic [CntW-1:0]            pat_len;
  logic [MaxPattern-1:0][7:0] pat_win;
  logic                       room2;
  wsm_pkg::wsm_push_t         push;

  wsm_cfg #(
    .MaxPattern (MaxPattern),
    .CntW       (CntW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pat_len_o   (pat_len),
    .pat_win_o   (pat_win)
  );

  wsm_scan #(
    .MaxPattern (MaxPattern),
    .CntW       (CntW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .pat_len_i  (pat_len),
    .pat_win_i  (pat_win),
    .room2_i    (room2),
    .push_o     (push)
  );

  wsm_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: test/testbench.sv
module testbench;
  import wsm_pkg::*;

  localparam int unsigned WindowLen = MaxPatternDefault;
  localparam int unsigned ItemTarget = 1700;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned DrainCycles = 8;
  localparam logic KindWord = 1'b0;
  localparam logic KindSummary = 1'b1;
  localparam logic [CfgIdxW-1:0] FirstUnusedReg = 3'd5;

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  class word_hit_board;
    logic [7:0] window [WindowLen];
    int unsigned word_len;
    bit in_word;
    bit hit;
    logic [31:0] words;
    logic [31:0] hits;
    logic [4:0] pat_len;
    logic [8*PatBytes-1:0] pat_bytes;
    wsm_out_t due_reports [$];
    int unsigned failures;

    function new();
      pat_len = '0;
      pat_bytes = '0;
      failures = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = '0;
      word_len = 0;
      in_word = 1'b0;
      hit = 1'b0;
      words = '0;
      hits = '0;
    endfunction

    function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegPatLen: pat_len = val[4:0];
        RegChars0: pat_bytes[63:0] = val;
        RegChars1: pat_bytes[127:64] = val;
        RegChars2: pat_bytes[191:128] = val;
        RegChars3: pat_bytes[199:192] = val[7:0];
        default: ;
      endcase
    endfunction

    function bit tail_hit();
      int unsigned len;
      len = (pat_len > WindowLen) ? WindowLen : pat_len;
      if (word_len < len) return 1'b0;
      for (int k = 0; k < len; k++) begin
        if (window[len - 1 - k] != fold_case(pat_bytes[k*8 +: 8])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_char(wsm_in_t it);
      bit alnum;
      alnum = is_word_char(it.text_char);
      if (alnum) begin
        if (!in_word) begin
          in_word = 1'b1;
          hit = 1'b0;
          word_len = 0;
          if (!(&words)) words++;
        end
        for (int i = WindowLen - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = fold_case(it.text_char);
        if (word_len < WindowLen) word_len++;
        if (tail_hit()) hit = 1'b1;
      end
      if (in_word && (!alnum || it.end_of_text)) begin
        if (hit) begin
          if (!(&hits)) hits++;
          due_reports.push_back('{report_kind: KindWord, word_number: words,
                                  matches_total: hits, final_flag: 1'b0});
        end
        in_word = 1'b0;
        hit = 1'b0;
        word_len = 0;
      end
      if (it.end_of_text) begin
        due_reports.push_back('{report_kind: KindSummary, word_number: 32'd0,
                                matches_total: hits, final_flag: 1'b1});
        clear_text();
      end
    endfunction

    function void check_report(wsm_out_t got);
      wsm_out_t want;
      if (due_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected item: kind %0d word %0d total %0d final %0d",
                   got.report_kind, got.word_number, got.matches_total, got.final_flag);
        return;
      end
      want = due_reports.pop_front();
      if (got.report_kind !== want.report_kind || got.word_number !== want.word_number ||
          got.matches_total !== want.matches_total || got.final_flag !== want.final_flag) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected kind %0d word %0d total %0d final %0d, got %0d %0d %0d %0d",
                   want.report_kind, want.word_number, want.matches_total, want.final_flag,
                   got.report_kind, got.word_number, got.matches_total, got.final_flag);
      end
    endfunction

    function int unsigned pending();
      return due_reports.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic cfg_ready;
  logic in_valid = 1'b0;
  wsm_in_t in_item = '0;
  logic in_stall;
  logic out_valid;
  wsm_out_t out_item;
  logic out_stall = 1'b0;

  word_hit_board board;
  wsm_in_t phase_text [$];
  logic [8*PatBytes-1:0] cur_pat = '0;
  logic [4:0] len_field = '0;
  int unsigned cur_len = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;
  bit hold_req = 1'b0;

  word_substring_matcher dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_stall_i (out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) board.check_report(out_item);
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin
    int unsigned mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (LongHold) @(posedge clk);
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic logic [7:0] rand_alnum(bit narrow);
    int unsigned span;
    span = narrow ? 2 : 25;
    case ($urandom_range(0, 2))
      0: return "0" + 8'($urandom_range(0, narrow ? 2 : 9));
      1: return "a" + 8'($urandom_range(0, span));
      default: return "A" + 8'($urandom_range(0, span));
    endcase
  endfunction

  function automatic logic [7:0] rand_separator();
    logic [7:0] c;
    do c = 8'($urandom); while (is_word_char(c));
    return c;
  endfunction

  function automatic logic [7:0] vary_case(logic [7:0] c);
    if ($urandom_range(0, 1) == 0) return c;
    if (c >= "a" && c <= "z") return c - 8'd32;
    if (c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  function automatic void add_char(logic [7:0] c, bit eot);
    phase_text.push_back('{text_char: c, end_of_text: eot});
  endfunction

  task automatic settle();
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.apply_reg(idx, val);
  endtask

  task automatic program_pattern();
    logic [CfgDataW-1:0] noise;
    settle();
    noise = {$urandom, $urandom};
    write_reg(RegPatLen, {noise[63:5], len_field});
    write_reg(RegChars0, cur_pat[63:0]);
    write_reg(RegChars1, cur_pat[127:64]);
    write_reg(RegChars2, cur_pat[191:128]);
    write_reg(RegChars3, {noise[55:0], cur_pat[199:192]});
    if ($urandom_range(0, 3) == 0)
      write_reg(FirstUnusedReg + 3'($urandom_range(0, 2)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_pattern();
    int unsigned style;
    bit narrow;
    style = $urandom_range(0, 9);
    case (style)
      0: len_field = 5'd0;
      1: len_field = 5'd1;
      2, 3, 4, 5: len_field = 5'($urandom_range(2, 4));
      6: len_field = 5'($urandom_range(5, 12));
      7: len_field = 5'd25;
      8: len_field = 5'($urandom_range(26, 31));
      default: len_field = 5'($urandom_range(2, 6));
    endcase
    cur_len = (len_field > WindowLen) ? WindowLen : len_field;
    narrow = $urandom_range(0, 3) != 0;
    for (int i = 0; i < PatBytes; i++)
      cur_pat[i*8 +: 8] = (i < cur_len) ? rand_alnum(narrow) : 8'($urandom);
    if (style == 9) cur_pat[$urandom_range(0, cur_len - 1)*8 +: 8] = rand_separator();
  endtask

  task automatic build_text(int unsigned tokens, bit finish);
    bit narrow;
    narrow = $urandom_range(0, 3) != 0;
    phase_text.delete();
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(0, 3)) add_char(rand_alnum(narrow), $urandom_range(0, 59) == 0);
          for (int k = 0; k < cur_len; k++)
            add_char(vary_case(cur_pat[k*8 +: 8]), $urandom_range(0, 59) == 0);
          repeat ($urandom_range(0, 3)) add_char(rand_alnum(narrow), $urandom_range(0, 59) == 0);
        end
        4, 5, 6: repeat ($urandom_range(1, 8))
          add_char(rand_alnum(narrow), $urandom_range(0, 59) == 0);
        7: repeat ($urandom_range(26, 40))
          add_char(rand_alnum(narrow), $urandom_range(0, 59) == 0);
        8: repeat ($urandom_range(1, 4)) add_char(8'($urandom), $urandom_range(0, 59) == 0);
        default: ;
      endcase
      repeat ($urandom_range(0, 2)) add_char(rand_separator(), $urandom_range(0, 59) == 0);
    end
    if (finish) add_char(8'($urandom), 1'b1);
  endtask

  task automatic send_item(wsm_in_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    board.note_char(it);
    items_sent++;
  endtask

  task automatic send_text(int pause_at);
    foreach (phase_text[i]) begin
      if (i == pause_at) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
      end else if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      send_item(phase_text[i]);
      if (burst_left != 0) burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    board = new();
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // empty pattern after reset: every word hits
    phase_text.delete();
    add_char("Z", 1'b0);
    add_char(" ", 1'b0);
    add_char(8'hff, 1'b0);
    add_char(8'h00, 1'b0);
    add_char("9", 1'b1);
    add_char(".", 1'b1);
    send_text(-1);

    // overlapping start, mixed case, word closed by the end-of-text byte
    cur_pat = '0;
    cur_pat[7:0] = "a";
    cur_pat[15:8] = "B";
    len_field = 5'd2;
    cur_len = 2;
    program_pattern();
    phase_text.delete();
    add_char("a", 1'b0);
    add_char("a", 1'b0);
    add_char("B", 1'b0);
    add_char("-", 1'b0);
    add_char("b", 1'b0);
    add_char("A", 1'b0);
    add_char(8'h80, 1'b0);
    add_char("z", 1'b0);
    add_char("A", 1'b0);
    add_char("b", 1'b1);
    send_text(-1);

    phase = 0;
    while (items_sent < ItemTarget) begin
      pick_pattern();
      program_pattern();
      build_text($urandom_range(4, 20), $urandom_range(0, 9) != 0);
      if (phase == 1 || phase == 6) hold_req = 1'b1;
      send_text((phase == 3) ? int'(phase_text.size() / 2) : -1);
      phase++;
    end

    settle();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
